// ----- rtl/core/cpi_pkg.sv -----
// ----------------------------------------------------------------------------
// cpi_pkg: shared types and constants of the cascaded PI motor controller
// Widths, fixed-point constants, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package cpi_pkg;

    localparam int SAMPLE_DEPTH_DEF = 128;
    localparam int ADC_BITS_DEF     = 12;
    localparam int MAX_ADC_BITS     = 16;

    localparam int CODE_W  = 12;
    localparam int DUTY_W  = 13;
    localparam int GAIN_W  = 24;
    localparam int BASE_W  = 23;
    localparam int CNT_W   = 10;
    localparam int COEF_W  = 32;
    localparam int VOLT_W  = 18;
    localparam int ERR_W   = 20;
    localparam int CUR_W   = 17;
    localparam int TAU_W   = 21;
    localparam int NUM_W   = 22;
    localparam int MAC_A_W = 33;
    localparam int MAC_B_W = 20;
    localparam int ACC_W   = 56;
    localparam int IDX_W   = 3;

    localparam int DUTY_LOW   = 1638;
    localparam int DUTY_HIGH  = 2457;
    localparam int SETTLE_THR = 655;
    localparam int FRAC_063   = 41288;
    localparam int SPD_GAIN   = 45613;
    localparam int SPD_OFFS   = 13697;
    localparam int VMAX       = 216269;
    localparam int HALF       = 32768;
    localparam int VOLT_MUL   = 33;
    localparam int VOLT_RND   = 5;
    localparam int VOLT_DIV   = 10;

    localparam int SPEED_GAIN_NOW_RST  = 404125;
    localparam int SPEED_GAIN_PREV_RST = -336920;
    localparam int SPEED_DIVIDER_RST   = 50;
    localparam int CUR_GAIN_BASE_RST   = 1130;
    localparam int CUR_GAIN_SLOPE_RST  = 2260;
    localparam int PRE_STEP_TICKS_RST  = 100;

    localparam logic [IDX_W-1:0] REG_SPEED_GAIN_NOW  = 3'd0;
    localparam logic [IDX_W-1:0] REG_SPEED_GAIN_PREV = 3'd1;
    localparam logic [IDX_W-1:0] REG_SPEED_DIVIDER   = 3'd2;
    localparam logic [IDX_W-1:0] REG_CUR_GAIN_BASE   = 3'd3;
    localparam logic [IDX_W-1:0] REG_CUR_GAIN_SLOPE  = 3'd4;
    localparam logic [IDX_W-1:0] REG_PRE_STEP_TICKS  = 3'd5;

    typedef struct packed {
        logic start;
        logic clear;
    } cpi_mac_ctl_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_CONV,
        ST_SAMPLE,
        ST_DECIM,
        ST_SPD_MUL,
        ST_SPD_ERR,
        ST_SPD_MAC1,
        ST_SPD_MAC2,
        ST_SPD_UPD,
        ST_CUR_MAC1,
        ST_CUR_MAC2,
        ST_CUR_UPD,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_TAU_MUL,
        ST_TAU_FIX,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_COEF_MUL,
        ST_COEF_UPD,
        ST_DONE
    } cpi_state_t;

endpackage

// ----- rtl/core/cascaded_pi_motor_controller.sv -----
// Ticks: pre-step, sampling, search, and tuned with or without the speed loop.
// One transaction at a time: in_stall holds off new inputs while the serial volt
// converter and the bit-serial multiplier work through the current one.
// Reset: asynchronous, active low; clears control state and loads register defaults.
// The sample RAM is not cleared; every entry is written before the search reads it.
// ----------------------------------------------------------------------------
// cascaded_pi_motor_controller: self-tuning cascaded speed/current PI loop
// Step-response tuning of the current loop, then decimated speed PI and
// per-tick current PI driving a 0..4096 duty.
// ----------------------------------------------------------------------------
module cascaded_pi_motor_controller import cpi_pkg::*; #(
    parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF,
    parameter int ADC_BITS     = ADC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_index,
    input  logic [GAIN_W-1:0] wr_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CODE_W-1:0] current_code,
    input  logic [CODE_W-1:0] setpoint_code,
    input  logic [CODE_W-1:0] speed_code,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DUTY_W-1:0] duty,
    output logic              tuned
);

    localparam int AW  = $clog2(SAMPLE_DEPTH);
    localparam int SCW = $clog2(SAMPLE_DEPTH + 1);

    localparam logic signed [ACC_W-1:0]  ACC_HALF  = ACC_W'(HALF);
    localparam logic signed [ACC_W-1:0]  ACC_HALFN = -ACC_W'(HALF);
    localparam logic signed [ACC_W-1:0]  ACC_VMAX  = ACC_W'(VMAX);
    localparam logic signed [ACC_W-1:0]  ACC_OFFS  = ACC_W'(SPD_OFFS);
    localparam logic signed [ACC_W-1:0]  I32_MAX   = ACC_W'(32'sh7FFF_FFFF);
    localparam logic signed [ACC_W-1:0]  I32_MIN   = -ACC_W'(64'sh8000_0000);
    localparam logic signed [VOLT_W:0]   THR_P     = (VOLT_W+1)'(SETTLE_THR);
    localparam logic signed [VOLT_W:0]   THR_N     = -(VOLT_W+1)'(SETTLE_THR);

    cpi_state_t state_reg, state_next;
    logic issued_reg, issued_next;
    logic [1:0] sel_reg, sel_next;

    logic signed [GAIN_W-1:0] sgn_reg, sgp_reg;
    logic [CNT_W-1:0]         div_reg, pre_ticks_reg;
    logic [BASE_W-1:0]        base_reg, slope_reg;

    logic [CNT_W-1:0] pre_cnt_reg, pre_cnt_next;
    logic [SCW-1:0]   smp_cnt_reg, smp_cnt_next;
    logic [CNT_W-1:0] dec_reg, dec_next;
    logic             tuned_reg, tuned_next;
    logic signed [COEF_W-1:0] cnow_reg, cnow_next, cprev_reg, cprev_next;
    logic signed [ERR_W-1:0]  spd_err_reg, spd_err_next;
    logic [VOLT_W-1:0]        spd_out_reg, spd_out_next;
    logic signed [ERR_W-1:0]  cur_err_reg, cur_err_next;
    logic signed [CUR_W-1:0]  cur_out_reg, cur_out_next;
    logic [DUTY_W-1:0]        duty_reg, duty_next;
    logic                     out_valid_reg, out_valid_next;
    logic [DUTY_W-1:0]        out_duty_reg, out_duty_next;
    logic                     out_tuned_reg, out_tuned_next;

    logic [ADC_BITS-1:0] cur_code_reg, set_code_reg, spd_code_reg;
    logic [VOLT_W-1:0]   v_cur_reg, v_cur_next, v_set_reg, v_set_next;
    logic [VOLT_W-1:0]   v_spd_reg, v_spd_next;
    logic signed [ERR_W-1:0] spd_e_reg, spd_e_next;
    logic [AW-1:0]       idx_reg, idx_next, i_reg, i_next, j_reg, j_next;
    logic [VOLT_W-1:0]   v1_reg, v1_next, prev_reg, prev_next, vi_reg, vi_next;
    logic signed [TAU_W-1:0] tau_reg, tau_next;

    logic [MAX_ADC_BITS-1:0] cur_ext, set_ext, spd_ext;
    logic                    in_acc;
    logic                    volt_start, volt_done;
    logic [ADC_BITS-1:0]     volt_code;
    logic [VOLT_W-1:0]       volt_q;
    cpi_mac_ctl_t            mac_ctl;
    logic signed [MAC_A_W-1:0] mac_a;
    logic signed [MAC_B_W-1:0] mac_b;
    logic                    mac_done;
    logic signed [ACC_W-1:0] mac_acc;
    logic                    ram_we;
    logic [VOLT_W-1:0]       ram_rdata;

    logic signed [ACC_W-1:0] acc_rnd, spd_e_wide, spd_y, cur_y, tau_wide;
    logic signed [ACC_W-1:0] coef_sum, coef_dif, q_sgn;
    logic [ACC_W-1:0]        p_abs, q_abs;
    logic signed [ERR_W-1:0] cur_e, rise;
    logic signed [CUR_W-1:0] cur_y_sat;
    logic signed [CUR_W:0]   duty_sum;
    logic [VOLT_W-1:0]       spd_y_sat;
    logic signed [COEF_W-1:0] cnow_sat, cprev_sat;
    logic signed [VOLT_W:0]  step_d;
    logic                    settle, above, out_free;
    logic [CNT_W-1:0]        dcn;

    assign cur_ext = MAX_ADC_BITS'(current_code);
    assign set_ext = MAX_ADC_BITS'(setpoint_code);
    assign spd_ext = MAX_ADC_BITS'(speed_code);
    assign in_stall = state_reg != ST_IDLE;
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign volt_code = (sel_reg == 2'd0) ? cur_code_reg :
                       (sel_reg == 2'd1) ? set_code_reg : spd_code_reg;

    cpi_volt #(
        .ADC_BITS (ADC_BITS)
    ) u_volt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (volt_start),
        .code  (volt_code),
        .done  (volt_done),
        .volts (volt_q)
    );

    cpi_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .a     (mac_a),
        .b     (mac_b),
        .done  (mac_done),
        .acc   (mac_acc)
    );

    cpi_ram #(
        .WIDTH (VOLT_W),
        .DEPTH (SAMPLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (smp_cnt_reg[AW-1:0]),
        .wdata (v_cur_reg),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign acc_rnd    = (mac_acc + ACC_HALF) >>> 16;
    assign spd_e_wide = $signed(ACC_W'(v_set_reg)) - (acc_rnd - ACC_OFFS);
    assign spd_y      = acc_rnd + $signed(ACC_W'(spd_out_reg));
    assign spd_y_sat  = (spd_y < 0) ? '0 : (spd_y > ACC_VMAX) ? VOLT_W'(VMAX)
                                                             : spd_y[VOLT_W-1:0];
    assign cur_e      = $signed({2'b00, spd_out_reg}) - $signed({2'b00, v_cur_reg});
    assign cur_y      = acc_rnd + {{(ACC_W - CUR_W){cur_out_reg[CUR_W-1]}}, cur_out_reg};
    assign cur_y_sat  = (cur_y < ACC_HALFN) ? -CUR_W'(HALF) :
                        (cur_y > ACC_HALF) ? CUR_W'(HALF) : cur_y[CUR_W-1:0];
    assign duty_sum   = {cur_y_sat[CUR_W-1], cur_y_sat} + (CUR_W+1)'(HALF);
    assign rise       = $signed({2'b00, vi_reg}) - $signed({2'b00, v1_reg});
    assign p_abs      = mac_acc[ACC_W-1] ? ACC_W'(-mac_acc) : ACC_W'(mac_acc);
    assign q_abs      = (p_abs + ACC_W'(HALF)) >> 16;
    assign q_sgn      = mac_acc[ACC_W-1] ? -$signed(q_abs) : $signed(q_abs);
    assign tau_wide   = $signed(ACC_W'(v1_reg)) + q_sgn;
    assign coef_sum   = $signed(ACC_W'(base_reg)) + mac_acc;
    assign coef_dif   = $signed(ACC_W'(base_reg)) - mac_acc;
    assign cnow_sat   = (coef_sum > I32_MAX) ? COEF_W'(I32_MAX) :
                        (coef_sum < I32_MIN) ? COEF_W'(I32_MIN) : coef_sum[COEF_W-1:0];
    assign cprev_sat  = (coef_dif > I32_MAX) ? COEF_W'(I32_MAX) :
                        (coef_dif < I32_MIN) ? COEF_W'(I32_MIN) : coef_dif[COEF_W-1:0];
    assign step_d     = $signed({1'b0, ram_rdata}) - $signed({1'b0, prev_reg});
    assign settle     = (step_d < THR_P) && (step_d > THR_N);
    assign above      = $signed({3'b000, ram_rdata}) > tau_reg;
    assign dcn        = dec_reg + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        issued_next    = issued_reg;
        sel_next       = sel_reg;
        pre_cnt_next   = pre_cnt_reg;
        smp_cnt_next   = smp_cnt_reg;
        dec_next       = dec_reg;
        tuned_next     = tuned_reg;
        cnow_next      = cnow_reg;
        cprev_next     = cprev_reg;
        spd_err_next   = spd_err_reg;
        spd_out_next   = spd_out_reg;
        cur_err_next   = cur_err_reg;
        cur_out_next   = cur_out_reg;
        duty_next      = duty_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_duty_next  = out_duty_reg;
        out_tuned_next = out_tuned_reg;
        v_cur_next     = v_cur_reg;
        v_set_next     = v_set_reg;
        v_spd_next     = v_spd_reg;
        spd_e_next     = spd_e_reg;
        idx_next       = idx_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        v1_next        = v1_reg;
        prev_next      = prev_reg;
        vi_next        = vi_reg;
        tau_next       = tau_reg;
        volt_start     = 1'b0;
        mac_ctl        = '0;
        mac_a          = '0;
        mac_b          = '0;
        ram_we         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                sel_next = 2'd0;
                if (tuned_reg)
                begin
                    state_next = ST_CONV;
                end
                else if (pre_cnt_reg < pre_ticks_reg)
                begin
                    duty_next    = DUTY_W'(DUTY_LOW);
                    pre_cnt_next = pre_cnt_reg + 1'b1;
                    state_next   = ST_DONE;
                end
                else if (smp_cnt_reg < SCW'(SAMPLE_DEPTH))
                begin
                    state_next = ST_CONV;
                end
                else
                begin
                    idx_next   = AW'(1);
                    state_next = ST_SRCH_RD;
                end
            end
            ST_CONV:
            begin
                volt_start  = !issued_reg;
                issued_next = 1'b1;
                if (volt_done)
                begin
                    issued_next = 1'b0;
                    case (sel_reg)
                        2'd0:    v_cur_next = volt_q;
                        2'd1:    v_set_next = volt_q;
                        default: v_spd_next = volt_q;
                    endcase
                    if (!tuned_reg)
                    begin
                        state_next = ST_SAMPLE;
                    end
                    else if (sel_reg == 2'd2)
                    begin
                        state_next = ST_DECIM;
                    end
                    else
                    begin
                        sel_next = sel_reg + 1'b1;
                    end
                end
            end
            ST_SAMPLE:
            begin
                ram_we       = 1'b1;
                smp_cnt_next = smp_cnt_reg + 1'b1;
                duty_next    = DUTY_W'(DUTY_HIGH);
                state_next   = ST_DONE;
            end
            ST_DECIM:
            begin
                if (dcn >= div_reg)
                begin
                    dec_next   = '0;
                    state_next = ST_SPD_MUL;
                end
                else
                begin
                    dec_next   = dcn;
                    state_next = ST_CUR_MAC1;
                end
            end
            ST_SPD_MUL:
            begin
                mac_ctl.start = !issued_reg;
                mac_ctl.clear = 1'b1;
                mac_a         = MAC_A_W'(SPD_GAIN);
                mac_b         = MAC_B_W'(v_spd_reg);
                issued_next   = 1'b1;
                if (mac_done)
                begin
                    issued_next = 1'b0;
                    state_next  = ST_SPD_ERR;
                end
            end
            ST_SPD_ERR:
            begin
                spd_e_next = spd_e_wide[ERR_W-1:0];
                state_next = ST_SPD_MAC1;
            end
            ST_SPD_MAC1:
            begin
                mac_ctl.start = !issued_reg;
                mac_ctl.clear = 1'b1;
                mac_a         = MAC_A_W'(sgn_reg);
                mac_b         = spd_e_reg;
                issued_next   = 1'b1;
                if (mac_done)
                begin
                    issued_next = 1'b0;
                    state_next  = ST_SPD_MAC2;
                end
            end
            ST_SPD_MAC2:
            begin
                mac_ctl.start = !issued_reg;
                mac_a         = MAC_A_W'(sgp_reg);
                mac_b         = spd_err_reg;
                issued_next   = 1'b1;
                if (mac_done)
                begin
                    issued_next = 1'b0;
                    state_next  = ST_SPD_UPD;
                end
            end
            ST_SPD_UPD:
            begin
                spd_err_next = spd_e_reg;
                spd_out_next = spd_y_sat;
                state_next   = ST_CUR_MAC1;
            end
            ST_CUR_MAC1:
            begin
                mac_ctl.start = !issued_reg;
                mac_ctl.clear = 1'b1;
                mac_a         = MAC_A_W'(cnow_reg);
                mac_b         = cur_e;
                issued_next   = 1'b1;
                if (mac_done)
                begin
                    issued_next = 1'b0;
                    state_next  = ST_CUR_MAC2;
                end
            end
            ST_CUR_MAC2:
            begin
                mac_ctl.start = !issued_reg;
                mac_a         = MAC_A_W'(cprev_reg);
                mac_b         = cur_err_reg;
                issued_next   = 1'b1;
                if (mac_done)
                begin
                    issued_next = 1'b0;
                    state_next  = ST_CUR_UPD;
                end
            end
            ST_CUR_UPD:
            begin
                cur_err_next = cur_e;
                cur_out_next = cur_y_sat;
                duty_next    = duty_sum[CUR_W-1:4];
                state_next   = ST_DONE;
            end
            ST_SRCH_RD:
            begin
                state_next = ST_SRCH_CHK;
            end
            ST_SRCH_CHK:
            begin
                prev_next = ram_rdata;
                if (idx_reg != AW'(1) && settle)
                begin
                    vi_next    = ram_rdata;
                    i_next     = idx_reg;
                    state_next = ST_TAU_MUL;
                end
                else if (idx_reg == AW'(SAMPLE_DEPTH - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SRCH_RD;
                end
                if (idx_reg == AW'(1))
                begin
                    v1_next = ram_rdata;
                end
            end
            ST_TAU_MUL:
            begin
                mac_ctl.start = !issued_reg;
                mac_ctl.clear = 1'b1;
                mac_a         = MAC_A_W'(FRAC_063);
                mac_b         = rise;
                issued_next   = 1'b1;
                if (mac_done)
                begin
                    issued_next = 1'b0;
                    state_next  = ST_TAU_FIX;
                end
            end
            ST_TAU_FIX:
            begin
                tau_next   = tau_wide[TAU_W-1:0];
                idx_next   = AW'(1);
                state_next = ST_SCAN_RD;
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                if (above)
                begin
                    j_next     = idx_reg;
                    state_next = ST_COEF_MUL;
                end
                else if (idx_reg + 1'b1 == i_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_COEF_MUL:
            begin
                mac_ctl.start = !issued_reg;
                mac_ctl.clear = 1'b1;
                mac_a         = MAC_A_W'(slope_reg);
                mac_b         = MAC_B_W'(j_reg);
                issued_next   = 1'b1;
                if (mac_done)
                begin
                    issued_next = 1'b0;
                    state_next  = ST_COEF_UPD;
                end
            end
            ST_COEF_UPD:
            begin
                cnow_next  = cnow_sat;
                cprev_next = cprev_sat;
                tuned_next = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_duty_next  = duty_reg;
                    out_tuned_next = tuned_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            sel_reg       <= '0;
            pre_cnt_reg   <= '0;
            smp_cnt_reg   <= '0;
            dec_reg       <= '0;
            tuned_reg     <= 1'b0;
            cnow_reg      <= '0;
            cprev_reg     <= '0;
            spd_err_reg   <= '0;
            spd_out_reg   <= '0;
            cur_err_reg   <= '0;
            cur_out_reg   <= '0;
            duty_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            sel_reg       <= sel_next;
            pre_cnt_reg   <= pre_cnt_next;
            smp_cnt_reg   <= smp_cnt_next;
            dec_reg       <= dec_next;
            tuned_reg     <= tuned_next;
            cnow_reg      <= cnow_next;
            cprev_reg     <= cprev_next;
            spd_err_reg   <= spd_err_next;
            spd_out_reg   <= spd_out_next;
            cur_err_reg   <= cur_err_next;
            cur_out_reg   <= cur_out_next;
            duty_reg      <= duty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cur_code_reg <= cur_ext[ADC_BITS-1:0];
            set_code_reg <= set_ext[ADC_BITS-1:0];
            spd_code_reg <= spd_ext[ADC_BITS-1:0];
        end
        out_duty_reg  <= out_duty_next;
        out_tuned_reg <= out_tuned_next;
        v_cur_reg     <= v_cur_next;
        v_set_reg     <= v_set_next;
        v_spd_reg     <= v_spd_next;
        spd_e_reg     <= spd_e_next;
        idx_reg       <= idx_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        v1_reg        <= v1_next;
        prev_reg      <= prev_next;
        vi_reg        <= vi_next;
        tau_reg       <= tau_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sgn_reg       <= GAIN_W'(SPEED_GAIN_NOW_RST);
            sgp_reg       <= GAIN_W'(SPEED_GAIN_PREV_RST);
            div_reg       <= CNT_W'(SPEED_DIVIDER_RST);
            base_reg      <= BASE_W'(CUR_GAIN_BASE_RST);
            slope_reg     <= BASE_W'(CUR_GAIN_SLOPE_RST);
            pre_ticks_reg <= CNT_W'(PRE_STEP_TICKS_RST);
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_SPEED_GAIN_NOW:  sgn_reg       <= $signed(wr_data);
                REG_SPEED_GAIN_PREV: sgp_reg       <= $signed(wr_data);
                REG_SPEED_DIVIDER:   div_reg       <= wr_data[CNT_W-1:0];
                REG_CUR_GAIN_BASE:   base_reg      <= wr_data[BASE_W-1:0];
                REG_CUR_GAIN_SLOPE:  slope_reg     <= wr_data[BASE_W-1:0];
                REG_PRE_STEP_TICKS:  pre_ticks_reg <= wr_data[CNT_W-1:0];
                default:             ;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign duty      = out_duty_reg;
    assign tuned     = out_tuned_reg;

    assert property (@(posedge clk) disable iff (!rst_n) tuned_reg |=> tuned_reg)
        else $error("tuned flag dropped");

    assert property (@(posedge clk) disable iff (!rst_n) in_acc |=> state_reg == ST_DISPATCH)
        else $error("transaction accepted outside idle");

    assert property (@(posedge clk) disable iff (!rst_n) spd_out_reg <= VOLT_W'(VMAX))
        else $error("speed loop output out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cur_out_reg <= CUR_W'(HALF)) && (cur_out_reg >= -CUR_W'(HALF)))
        else $error("current loop output out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        !tuned_reg |-> (duty_reg == '0 || duty_reg == DUTY_W'(DUTY_LOW)
                        || duty_reg == DUTY_W'(DUTY_HIGH)))
        else $error("untuned duty not a tuning level");

endmodule

// ----- rtl/core/cpi_ram.sv -----
// ----------------------------------------------------------------------------
// cpi_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cpi_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/cpi_volt.sv -----
// ----------------------------------------------------------------------------
// cpi_volt: serial ADC code to Q2.16 volt converter
// Rounds code * 3.3 / full scale by a one-bit-per-cycle division by ten.
// ----------------------------------------------------------------------------
module cpi_volt import cpi_pkg::*; #(
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [ADC_BITS-1:0] code,
    output logic                done,
    output logic [VOLT_W-1:0]   volts
);

    localparam int VCNT_W = $clog2(NUM_W);

    logic              run_reg;
    logic              done_reg;
    logic [VCNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [3:0]        rem_reg;
    logic [NUM_W-1:0]  num_init;
    logic [4:0]        rem_shift;
    logic              rem_ge;
    logic              last;

    assign num_init  = ((NUM_W'(code) * NUM_W'(VOLT_MUL)) << (MAX_ADC_BITS - ADC_BITS))
                       + NUM_W'(VOLT_RND);
    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign rem_ge    = rem_shift >= 5'(VOLT_DIV);
    assign last      = cnt_reg == VCNT_W'(NUM_W - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (run_reg)
        begin
            cnt_reg  <= cnt_reg + 1'b1;
            run_reg  <= !last;
            done_reg <= last;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num_init;
            quo_reg <= '0;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            num_reg <= num_reg << 1;
            quo_reg <= {quo_reg[NUM_W-2:0], rem_ge};
            rem_reg <= rem_ge ? 4'(rem_shift - 5'(VOLT_DIV)) : rem_shift[3:0];
        end
    end

    assign done  = done_reg;
    assign volts = quo_reg[VOLT_W-1:0];

endmodule

// ----- rtl/core/cpi_mac.sv -----
// ----------------------------------------------------------------------------
// cpi_mac: bit-serial signed multiply-accumulate unit
// Shift-and-add over the multiplier bits, one bit per cycle.
// ----------------------------------------------------------------------------
module cpi_mac import cpi_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cpi_mac_ctl_t              ctl,
    input  logic signed [MAC_A_W-1:0] a,
    input  logic signed [MAC_B_W-1:0] b,
    output logic                      done,
    output logic signed [ACC_W-1:0]   acc
);

    localparam int MCNT_W = $clog2(MAC_B_W);

    logic                    run_reg;
    logic                    done_reg;
    logic [MCNT_W-1:0]       cnt_reg;
    logic signed [ACC_W-1:0] m_reg;
    logic [MAC_B_W-1:0]      b_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic                    last;

    assign last = cnt_reg == MCNT_W'(MAC_B_W - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctl.start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (run_reg)
        begin
            cnt_reg  <= cnt_reg + 1'b1;
            run_reg  <= !last;
            done_reg <= last;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            m_reg <= {{(ACC_W - MAC_A_W){a[MAC_A_W-1]}}, a};
            b_reg <= b;
            if (ctl.clear)
            begin
                acc_reg <= '0;
            end
        end
        else if (run_reg)
        begin
            if (b_reg[0])
            begin
                acc_reg <= last ? acc_reg - m_reg : acc_reg + m_reg;
            end
            m_reg <= m_reg <<< 1;
            b_reg <= b_reg >> 1;
        end
    end

    assign done = done_reg;
    assign acc  = acc_reg;

endmodule
